// ===== design/fp16s_pkg.sv =====
// Shared types, constants and the binary16 rounding function for the sinh pipeline.
`timescale 1ns / 1ps

package fp16s_pkg;

  // Canonical quiet NaN, positive and negative infinity, and positive zero.
  localparam logic [15:0] H_QNAN = 16'h7E00;
  localparam logic [15:0] H_PINF = 16'h7C00;
  localparam logic [15:0] H_NINF = 16'hFC00;
  localparam logic [15:0] H_ZERO = 16'h0000;

  // Result of the exponential section.
  typedef struct packed {
    logic        nan;
    logic [15:0] e;
  } exp_res_t;

  // Result of the reciprocal section.
  typedef struct packed {
    logic        nan;
    logic [15:0] e;
    logic [15:0] r;
  } rcp_res_t;

  // Rounds sgn * frac * 2^eu to binary16, round to nearest even.
  // frac holds the leading one at bit 39. Subnormal results are shifted
  // right with sticky collection; overflow becomes infinity.
  function automatic logic [15:0] round_pack(input logic sgn, input logic signed [7:0] eu,
                                             input logic [39:0] frac, input logic sticky);
    logic signed [8:0] dsh;
    logic [3:0]        sh;
    logic [51:0]       wide;
    logic [51:0]       shifted;
    logic [51:0]       lmask;
    logic [4:0]        bexp;
    logic [9:0]        mant;
    logic              guard;
    logic              st;
    logic              inc;
    logic [14:0]       body;
    wide    = {frac, 12'd0};
    dsh     = -9'sd14 - 9'(eu);
    sh      = (dsh > 9'sd12) ? 4'd12 : dsh[3:0];
    shifted = wide >> sh;
    lmask   = (52'd1 << sh) - 52'd1;
    if (eu >= -8'sd14) begin
      bexp  = 5'(eu + 8'sd15);
      mant  = frac[38:29];
      guard = frac[28];
      st    = (|frac[27:0]) | sticky;
    end else begin
      bexp  = 5'd0;
      mant  = shifted[50:41];
      guard = shifted[40];
      st    = (|shifted[39:0]) | (|(wide & lmask)) | sticky;
    end
    inc  = guard & (st | mant[0]);
    // A carry out of the mantissa moves into the exponent field.
    body = {bexp, mant} + 15'(inc);
    if (eu > 8'sd15) begin
      body = H_PINF[14:0];
    end
    return {sgn, body};
  endfunction

endpackage

// ===== design/fp16s_exp.sv =====
// Pipelined binary16 exponential: range reduction, Horner polynomial, rounding.
`timescale 1ns / 1ps

module fp16s_exp (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         x_bits,
  output logic                out_valid,
  output fp16s_pkg::exp_res_t res
);
  import fp16s_pkg::*;

  localparam int NH = 9;
  localparam logic [14:0] X_OVF = 15'h4A00;   // 12.0
  localparam logic [14:0] X_UNF = 15'h4C80;   // 18.0
  localparam logic [17:0] INV_LN2_Q17 = 18'h2E2A9;
  localparam logic [39:0] LN2_Q40 = 40'hB17217F7D2;
  localparam logic signed [34:0] HORNER_C9 = 35'sh0_0000_2E3C;
  // Taylor coefficients 1/n! in Q.32, from n = 8 down to n = 0.
  localparam logic signed [34:0] HORNER_C [NH] = '{
    35'sh0_0001_A01A, 35'sh0_000D_00D0, 35'sh0_005B_05B0, 35'sh0_0222_2222,
    35'sh0_0AAA_AAAB, 35'sh0_2AAA_AAAB, 35'sh0_8000_0000, 35'sh1_0000_0000,
    35'sh1_0000_0000
  };

  typedef struct packed {
    logic              ovf;
    logic              unf;
    logic              nan;
    logic signed [5:0] k;
  } side_t;

  // Stage 1: decode the operand into signed fixed point with 32 fraction bits.
  logic [4:0]         xe;
  logic [10:0]        sig;
  logic [5:0]         shamt;
  logic [36:0]        mag;
  logic               v1;
  logic signed [37:0] xfix1;
  side_t              s1;

  always_comb begin
    xe    = x_bits[14:10];
    sig   = (xe == 5'd0) ? {1'b0, x_bits[9:0]} : {1'b1, x_bits[9:0]};
    shamt = (xe == 5'd0) ? 6'd8 : ({1'b0, xe} + 6'd7);
    mag   = 37'(sig) << shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xfix1  <= x_bits[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      s1.ovf <= !x_bits[15] && (x_bits[14:0] > X_OVF);
      s1.unf <= x_bits[15] && (x_bits[14:0] > X_UNF);
      s1.nan <= (xe == 5'h1F) && (x_bits[9:0] != 10'd0);
      s1.k   <= 6'sd0;
    end
  end

  // Stage 2: estimate k = round(x / ln2) from a coarse copy of x.
  logic signed [40:0] kprod;
  logic signed [40:0] kround;
  logic               v2;
  logic signed [37:0] xfix2;
  side_t              s2;

  always_comb begin
    kprod  = $signed(xfix1[37:16]) * $signed({1'b0, INV_LN2_Q17});
    kround = (kprod + (41'sd1 <<< 32)) >>> 33;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xfix2 <= xfix1;
      s2    <= '{ovf: s1.ovf, unf: s1.unf, nan: s1.nan, k: $signed(kround[5:0])};
    end
  end

  // Stage 3: reduced argument r = x - k*ln2, which seeds the Horner chain.
  logic signed [46:0] kl;
  logic signed [47:0] r40;
  logic               hv [NH+1];
  logic signed [32:0] hr [NH+1];
  logic signed [34:0] hp [NH+1];
  side_t              hs [NH+1];
  logic signed [67:0] hprod [NH];
  logic signed [34:0] hnext [NH];

  always_comb begin
    kl  = s2.k * $signed({1'b0, LN2_Q40});
    r40 = (48'(xfix2) <<< 8) - 48'(kl);
  end

  // Horner steps: p <- c + r*p, one multiply per stage.
  always_comb begin
    for (int j = 0; j < NH; j++) begin
      hprod[j] = hr[j] * hp[j];
      hnext[j] = HORNER_C[j] + $signed(hprod[j][66:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NH; j++) begin
        hv[j] <= 1'b0;
      end
    end else if (en) begin
      hv[0] <= v2;
      for (int j = 1; j <= NH; j++) begin
        hv[j] <= hv[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hr[0] <= $signed(r40[40:8]);
      hp[0] <= HORNER_C9;
      hs[0] <= s2;
      for (int j = 1; j <= NH; j++) begin
        hr[j] <= hr[j-1];
        hp[j] <= hnext[j-1];
        hs[j] <= hs[j-1];
      end
    end
  end

  // Last stage: normalize exp(r) * 2^k and round to binary16.
  logic [34:0]       pfin;
  logic [39:0]       efrac;
  logic signed [7:0] eu;
  logic [15:0]       eround;

  always_comb begin
    pfin = hp[NH];
    if (pfin[32]) begin
      efrac = {pfin[32:0], 7'd0};
      eu    = 8'(hs[NH].k);
    end else begin
      efrac = {pfin[31:0], 8'd0};
      eu    = 8'(hs[NH].k) - 8'sd1;
    end
    eround = round_pack(1'b0, eu, efrac, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= hv[NH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.nan <= hs[NH].nan;
      res.e   <= hs[NH].ovf ? H_PINF : (hs[NH].unf ? H_ZERO : eround);
    end
  end

endmodule

// ===== design/fp16s_rcp.sv =====
// Pipelined binary16 reciprocal using restoring division, three quotient bits per stage.
`timescale 1ns / 1ps

module fp16s_rcp (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  fp16s_pkg::exp_res_t in_res,
  output logic                out_valid,
  output fp16s_pkg::rcp_res_t res
);
  import fp16s_pkg::*;

  localparam int ND = 5;
  localparam int BPS = 3;

  typedef struct packed {
    logic              nan;
    logic              zero_e;
    logic              inf_e;
    logic [15:0]       e;
    logic signed [6:0] ee;
    logic [10:0]       m;
  } side_t;

  // Stage 1: normalize the divisor, including subnormal operands.
  logic [4:0] xe;
  logic [9:0] em;
  logic [3:0] lz;
  logic       found;
  side_t      nside;

  always_comb begin
    xe    = in_res.e[14:10];
    em    = in_res.e[9:0];
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (em[i]) begin
          found = 1'b1;
        end else begin
          lz = lz + 4'd1;
        end
      end
    end
    nside.nan    = in_res.nan;
    nside.zero_e = (in_res.e == H_ZERO);
    nside.inf_e  = (in_res.e == H_PINF);
    nside.e      = in_res.e;
    if (xe != 5'd0) begin
      nside.m  = {1'b1, em};
      nside.ee = $signed({2'b00, xe}) - 7'sd15;
    end else begin
      nside.m  = {em, 1'b0} << lz;
      nside.ee = -7'sd15 - $signed({3'b000, lz});
    end
  end

  // Division stages: quotient of 1/m, first bit is the integer bit.
  logic        dv [ND+1];
  logic [12:0] dr [ND+1];
  logic [14:0] dq [ND+1];
  side_t       ds [ND+1];
  logic [12:0] rnext [ND];
  logic [14:0] qnext [ND];
  logic [12:0] rem;
  logic [14:0] quo;

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      rem = dr[j];
      quo = dq[j];
      for (int s = 0; s < BPS; s++) begin
        if (rem >= {2'b00, ds[j].m}) begin
          rem = rem - {2'b00, ds[j].m};
          quo = {quo[13:0], 1'b1};
        end else begin
          quo = {quo[13:0], 1'b0};
        end
        rem = rem << 1;
      end
      rnext[j] = rem;
      qnext[j] = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= ND; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= in_valid;
      for (int j = 1; j <= ND; j++) begin
        dv[j] <= dv[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0] <= 13'd1024;
      dq[0] <= 15'd0;
      ds[0] <= nside;
      for (int j = 1; j <= ND; j++) begin
        dr[j] <= rnext[j-1];
        dq[j] <= qnext[j-1];
        ds[j] <= ds[j-1];
      end
    end
  end

  // Last stage: normalize the quotient and round.
  logic [39:0]       qfrac;
  logic signed [7:0] qeu;
  logic [15:0]       rround;

  always_comb begin
    if (dq[ND][14]) begin
      qfrac = {dq[ND], 25'd0};
      qeu   = -8'(ds[ND].ee);
    end else begin
      qfrac = {dq[ND][13:0], 26'd0};
      qeu   = -8'(ds[ND].ee) - 8'sd1;
    end
    rround = round_pack(1'b0, qeu, qfrac, dr[ND] != 13'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.nan <= ds[ND].nan;
      res.e   <= ds[ND].e;
      if (ds[ND].zero_e) begin
        res.r <= H_PINF;
      end else if (ds[ND].inf_e) begin
        res.r <= H_ZERO;
      end else begin
        res.r <= rround;
      end
    end
  end

endmodule

// ===== design/fp16s_sub.sv =====
// Pipelined exact difference e - r, rounding, and halving to give the final result.
`timescale 1ns / 1ps

module fp16s_sub (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  fp16s_pkg::rcp_res_t in_res,
  output logic                out_valid,
  output logic [15:0]         y_bits
);
  import fp16s_pkg::*;

  // Finite binary16 as an unsigned integer in units of 2^-24.
  function automatic logic [39:0] to_fix(input logic [15:0] h);
    logic [4:0]  ex;
    logic [10:0] sig;
    logic [4:0]  sh;
    ex  = h[14:10];
    sig = (ex == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    sh  = (ex == 5'd0) ? 5'd0 : (ex - 5'd1);
    return 40'(sig) << sh;
  endfunction

  // Stage 1: aligned subtraction in wide fixed point, exact.
  logic [40:0] diff;
  logic [40:0] ndiff;
  logic        v1;
  logic        neg1;
  logic [39:0] mag1;
  logic        pinf1;
  logic        ninf1;
  logic        nan1;

  always_comb begin
    diff  = {1'b0, to_fix(in_res.e)} - {1'b0, to_fix(in_res.r)};
    ndiff = -diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= diff[40];
      mag1  <= diff[40] ? ndiff[39:0] : diff[39:0];
      pinf1 <= (in_res.e == H_PINF);
      ninf1 <= (in_res.r == H_PINF);
      nan1  <= in_res.nan;
    end
  end

  // Stage 2: leading-zero count of the magnitude.
  logic [5:0]  lzc;
  logic        found;
  logic        v2;
  logic        neg2;
  logic [39:0] mag2;
  logic [5:0]  lz2;
  logic        pinf2;
  logic        ninf2;
  logic        nan2;

  always_comb begin
    lzc   = 6'd0;
    found = 1'b0;
    for (int i = 39; i >= 0; i--) begin
      if (!found) begin
        if (mag1[i]) begin
          found = 1'b1;
        end else begin
          lzc = lzc + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2  <= neg1;
      mag2  <= mag1;
      lz2   <= lzc;
      pinf2 <= pinf1;
      ninf2 <= ninf1;
      nan2  <= nan1;
    end
  end

  // Stage 3: normalize and round the difference.
  logic [39:0]       dfrac;
  logic signed [7:0] deu;
  logic [15:0]       dround;
  logic              v3;
  logic [15:0]       d3;
  logic              nan3;

  always_comb begin
    dfrac  = mag2 << lz2;
    deu    = 8'sd15 - $signed({2'b00, lz2});
    dround = round_pack(neg2, deu, dfrac, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nan3 <= nan2;
      if (pinf2) begin
        d3 <= H_PINF;
      end else if (ninf2) begin
        d3 <= H_NINF;
      end else if (mag2 == 40'd0) begin
        d3 <= H_ZERO;
      end else begin
        d3 <= dround;
      end
    end
  end

  // Stage 4: multiply by one half, rounding when the result is subnormal.
  logic [4:0]  dex;
  logic [10:0] hsig;
  logic [10:0] hhalf;
  logic [15:0] yh;

  always_comb begin
    dex   = d3[14:10];
    hsig  = {dex[0], d3[9:0]};
    hhalf = (hsig >> 1) + 11'(hsig[0] & hsig[1]);
    if (dex == 5'h1F) begin
      yh = d3;
    end else if (dex >= 5'd2) begin
      yh = {d3[15], dex - 5'd1, d3[9:0]};
    end else begin
      yh = {d3[15], 15'(hhalf)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_bits <= nan3 ? H_QNAN : yh;
    end
  end

endmodule

// ===== design/fp16_sinh_core.sv =====
// Top level of the binary16 hyperbolic sine pipeline.
`timescale 1ns / 1ps
// An accepted item passes through the exponential, reciprocal and subtract sections in that order.
// Throughput: one item per cycle; every stage holds while the output register is stalled.
// The rate is set by the single shared advance enable of the pipeline registers.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.

module fp16_sinh_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] y_bits
);
  import fp16s_pkg::*;

  logic     adv;
  logic     e_valid;
  exp_res_t e_res;
  logic     r_valid;
  rcp_res_t r_res;

  // The whole pipeline advances unless a finished item is waiting.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  fp16s_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .x_bits    (x_bits),
    .out_valid (e_valid),
    .res       (e_res)
  );

  fp16s_rcp u_rcp (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_valid),
    .in_res    (e_res),
    .out_valid (r_valid),
    .res       (r_res)
  );

  fp16s_sub u_sub (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .in_res    (r_res),
    .out_valid (out_valid),
    .y_bits    (y_bits)
  );

`ifndef SYNTHESIS
  // Any NaN leaving the block is the canonical quiet NaN.
  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (y_bits[14:10] == 5'h1F) && (y_bits[9:0] != 10'd0)) |-> (y_bits == H_QNAN))
    else $error("non-canonical NaN on the output");

  // The exponential never produces a negative value.
  a_exp_pos: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> !e_res.e[15])
    else $error("exponential result has its sign bit set");

  // The reciprocal is never negative, and an infinite exponential gives zero.
  a_rcp_inf: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (!r_res.r[15] && ((r_res.e != H_PINF) || (r_res.r == H_ZERO))))
    else $error("reciprocal result is inconsistent with its operand");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the binary16 hyperbolic sine pipeline.
`timescale 1ns / 1ps

module tb;
  import fp16s_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] x_bits;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] y_bits;

  logic [15:0] operand_queue[$];
  logic [15:0] sinh_expected[$];
  int          sent_count;
  int          recv_count;
  int          error_count;
  int          cycle_count;

  fp16_sinh_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .x_bits(x_bits),
    .out_valid(out_valid), .out_ready(out_ready), .y_bits(y_bits)
  );

  // Power of two as a double, built from its bit pattern.
  function automatic real two_to(input int p);
    logic [63:0] b;
    b = 64'(p + 1023) << 52;
    return $bitstoreal(b);
  endfunction

  // Binary16 pattern to real; NaN patterns are screened out by the caller.
  function automatic real half_to_real(input logic [15:0] h);
    real v;
    if (h[14:10] == 5'h1F) begin
      v = $bitstoreal(64'h7FF0000000000000);
    end else if (h[14:10] == 5'd0) begin
      v = real'(h[9:0]) * two_to(-24);
    end else begin
      v = real'({1'b1, h[9:0]}) * two_to(int'(h[14:10]) - 25);
    end
    return h[15] ? -v : v;
  endfunction

  // Nearest integer of a nonnegative value, ties to even.
  function automatic int unsigned round_even(input real q);
    int unsigned n;
    real f;
    n = $rtoi(q);
    f = q - real'(n);
    if (f > 0.5 || (f == 0.5 && n[0])) n++;
    return n;
  endfunction

  // Real to binary16 with round to nearest even and IEEE overflow.
  function automatic logic [15:0] real_to_half(input real v);
    logic sgn;
    real a;
    int ex;
    int unsigned q;
    if (v != v) return H_QNAN;
    sgn = (v < 0.0);
    a = sgn ? -v : v;
    if (a >= 65520.0) return {sgn, H_PINF[14:0]};
    if (a < two_to(-14)) begin
      q = round_even(a * two_to(24));
      return {sgn, 15'(q)};
    end
    ex = 15;
    while (ex > -14 && a < two_to(ex)) ex--;
    q = round_even(a * two_to(10 - ex));
    if (q >= 2048) begin
      q = 1024;
      ex++;
    end
    if (ex > 15) return {sgn, H_PINF[14:0]};
    return {sgn, 5'(ex + 15), 10'(q - 1024)};
  endfunction

  // Correctly rounded exp of a binary16 operand.
  function automatic logic [15:0] half_exp(input logic [15:0] x);
    real v, t, r, s;
    int k;
    if (x[14:0] == H_PINF[14:0]) return x[15] ? H_ZERO : H_PINF;
    v = half_to_real(x);
    if (v > 12.0) return H_PINF;
    if (v < -18.0) return H_ZERO;
    t = v * 1.44269504088896338700;
    k = $rtoi(t + ((t >= 0.0) ? 0.5 : -0.5));
    r = (v - real'(k) * 6.93147180369123816490e-01) - real'(k) * 1.90821492927058770002e-10;
    s = 1.0;
    for (int i = 18; i >= 1; i--) s = 1.0 + r * s / real'(i);
    return real_to_half(s * two_to(k));
  endfunction

  // Four rounded steps: exp, reciprocal, difference, halving.
  function automatic logic [15:0] predict_sinh(input logic [15:0] x);
    logic [15:0] e, r, d;
    if (x[14:10] == 5'h1F && x[9:0] != 10'd0) return H_QNAN;
    e = half_exp(x);
    if (e == H_ZERO) r = H_PINF;
    else if (e == H_PINF) r = H_ZERO;
    else r = real_to_half(1.0 / half_to_real(e));
    d = real_to_half(half_to_real(e) - half_to_real(r));
    return real_to_half(half_to_real(d) * 0.5);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: record the expectation of each accepted item, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      x_bits   <= 16'd0;
    end else begin
      if (in_valid && in_ready) begin
        sinh_expected.push_back(predict_sinh(x_bits));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (operand_queue.size() != 0 &&
            ((sent_count > 300 && sent_count < 450) || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          x_bits   <= operand_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, one long hold-off, and a stretch with none.
  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= 200 && cycle_count < 500) out_ready <= 1'b0;
      else if (cycle_count >= 800 && cycle_count < 1100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      recv_count++;
      if (sinh_expected.size() == 0) begin
        report_mismatch("unexpected item", y_bits, 16'd0);
      end else begin
        logic [15:0] want;
        want = sinh_expected.pop_front();
        if (y_bits !== want) report_mismatch("y_bits", y_bits, want);
      end
    end
  end

  // Stimulus: directed corner operands, then random ones, then drain and verdict.
  initial begin
    logic [15:0] directed[];
    directed = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                 16'h7C01, 16'hFFFF, 16'h0001, 16'h8001, 16'h03FF,
                 16'h83FF, 16'h0400, 16'h3C00, 16'hBC00, 16'h4A00,
                 16'h4A01, 16'hC98C, 16'hC98D, 16'hCA00, 16'hCC80,
                 16'h7BFF, 16'hFBFF, 16'h3800, 16'hB800, 16'h1400};
    sent_count  = 0;
    recv_count  = 0;
    error_count = 0;
    foreach (directed[i]) operand_queue.push_back(directed[i]);
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        operand_queue.push_back(16'($urandom_range(0, 65535)));
      end else begin
        // Most operands land where sinh is finite and nontrivial.
        operand_queue.push_back({1'($urandom_range(0, 1)), 5'($urandom_range(0, 19)),
                                 10'($urandom_range(0, 1023))});
      end
    end
    @(negedge rst);
    while (operand_queue.size() != 0 || in_valid) @(posedge clk);
    while (sinh_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d operands (zeros, subnormals, infinities, NaNs, overflow edges, random)",
             sent_count);
    $display("through random stalls and a long output hold-off; %0d results checked.",
             recv_count);
    if (error_count == 0 && sinh_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", sinh_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fp16s_pkg.sv
design/fp16s_exp.sv
design/fp16s_rcp.sv
design/fp16s_sub.sv
design/fp16_sinh_core.sv
bench/tb.sv
